// ===== rtl/max_area_triangle_search_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef MAX_AREA_TRIANGLE_SEARCH_UNIT_DEFINES_SVH
`define MAX_AREA_TRIANGLE_SEARCH_UNIT_DEFINES_SVH

// clocked assertion, muted while reset is low
`define MATS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define MATS_ASSERT_RST(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mats_pkg.sv =====
// shared constants, types and helpers of the triangle search unit
package mats_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 16;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int AREA_W     = 34;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = (CROSS_W > AREA_W) ? CROSS_W : AREA_W;
    localparam int MIN_POINTS = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    // classified input beat as it crosses the queue
    typedef struct packed {
        t_point           pt;
        logic             store;
        logic             last;
        logic             dropped;
        logic [CNT_W-1:0] cnt;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } t_tag;

    typedef struct packed {
        logic [OUT_W-1:0]  first_x;
        logic [OUT_W-1:0]  first_y;
        logic [OUT_W-1:0]  second_x;
        logic [OUT_W-1:0]  second_y;
        logic [OUT_W-1:0]  third_x;
        logic [OUT_W-1:0]  third_y;
        logic [AREA_W-1:0] double_area;
        logic              found;
        logic              overflow;
    } t_result;

    // low bits of the port value, read as a signed coordinate
    function automatic logic signed [COORD_BITS-1:0] from_in(input logic [IN_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[COORD_BITS-1:0];
    endfunction

    // sign extend (or trim) a coordinate to the result field width
    function automatic logic [OUT_W-1:0] to_out(input logic signed [COORD_BITS-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/max_area_triangle_search_unit.sv =====
// top level of the largest-area triangle search unit
//
//  channel  handshake       payload
//  points   push / full     i_x_coord, i_y_coord, i_last_point
//  result   empty / pop     o_first_x .. o_third_y, o_double_area, o_found, o_overflow
//
// points load at one beat per cycle while full is low, into a 32-entry store through a
// 4-deep queue. after the last point of n stored (n of 3 or more), the scan fetches both
// anchors of each (i, j) pair in S_FETCH_I and S_FETCH_J, then sweeps k in S_SCAN; it then
// drains the pipeline, reads back the winner in S_RES_A .. S_RES_C and hands over in S_EMIT.
// while a scan runs the queue takes up to 4 further beats, then full rises.
// a result waiting unpopped stalls only the next hand-over; no clearing pass after reset.
module max_area_triangle_search_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [15:0]          i_x_coord,
    input  logic signed [15:0]          i_y_coord,
    input  logic                        i_last_point,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [15:0]          o_first_x,
    output logic signed [15:0]          o_first_y,
    output logic signed [15:0]          o_second_x,
    output logic signed [15:0]          o_second_y,
    output logic signed [15:0]          o_third_x,
    output logic signed [15:0]          o_third_y,
    output logic [mats_pkg::AREA_W-1:0] o_double_area,
    output logic                        o_found,
    output logic                        o_overflow
);
    import mats_pkg::*;

    t_item   front_item;
    t_item   q_item;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_result result;

    mats_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_last_point (i_last_point),
        .o_full       (full),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_item       (front_item)
    );

    mats_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    mats_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_empty (q_empty),
        .o_item_pop   (q_pop),
        .o_result     (result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    assign o_first_x     = result.first_x;
    assign o_first_y     = result.first_y;
    assign o_second_x    = result.second_x;
    assign o_second_y    = result.second_y;
    assign o_third_x     = result.third_x;
    assign o_third_y     = result.third_y;
    assign o_double_area = result.double_area;
    assign o_found       = result.found;
    assign o_overflow    = result.overflow;

endmodule

// ===== rtl/mats_fifo.sv =====
// short queue of classified points between the front and the search engine
module mats_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mats_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output mats_pkg::t_item o_item,
    output logic            o_empty
);
    import mats_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               wr_en;
    logic               rd_en;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + FIFO_AW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + FIFO_AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + FIFO_CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/mats_front.sv =====
// input side: takes point beats, counts the set and marks dropped points
module mats_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [mats_pkg::IN_W-1:0] i_x_coord,
    input  logic [mats_pkg::IN_W-1:0] i_y_coord,
    input  logic                      i_last_point,
    output logic                      o_full,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output mats_pkg::t_item           o_item
);
    import mats_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_dropped, n_dropped;
    logic             store;

    assign store    = (r_cnt < CNT_W'(MAX_POINTS));
    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_item.pt.x    = from_in(i_x_coord);
        o_item.pt.y    = from_in(i_y_coord);
        o_item.store   = store;
        o_item.last    = i_last_point;
        o_item.dropped = r_dropped || !store;
        o_item.cnt     = store ? r_cnt + CNT_W'(1) : r_cnt;
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_dropped = r_dropped;
        if (o_q_push) begin
            if (i_last_point) begin
                n_cnt     = '0;
                n_dropped = 1'b0;
            end else begin
                n_cnt     = o_item.cnt;
                n_dropped = o_item.dropped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_dropped <= n_dropped;
        end
    end

endmodule

// ===== rtl/mats_scan.sv =====
// search engine: point store, triple scan pipeline, best tracking and result register
module mats_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mats_pkg::t_item   i_item,
    input  logic              i_item_empty,
    output logic              o_item_pop,
    output mats_pkg::t_result o_result,
    output logic              o_empty,
    input  logic              i_pop
);
    import mats_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH_I,
        S_FETCH_J,
        S_SCAN,
        S_DRAIN,
        S_RES_A,
        S_RES_B,
        S_RES_C,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_n, n_n;
    logic              r_dropped, n_dropped;
    logic [AREA_W-1:0] r_best, n_best;
    t_tag              r_best_tag, n_best_tag;
    t_result           r_res, n_res;
    t_result           r_out, n_out;
    logic              r_out_v, n_out_v;

    // point store and its two registered read ports
    t_point            r_mem [MAX_POINTS];
    t_point            r_rd_a;
    t_point            r_rd_b;
    logic [IDX_W-1:0]  addr_a;
    logic [IDX_W-1:0]  addr_b;
    logic [CNT_W-1:0]  wr_cnt;
    logic              wr_en;

    // scan pipeline
    t_point                    r_pi;
    logic                      r_rd_v;
    t_tag                      r_rd_tag;
    logic                      r_s1_v;
    t_tag                      r_s1_tag;
    logic signed [DIFF_W-1:0]  r_s1_d1x, r_s1_d1y, r_s1_d2x, r_s1_d2y;
    logic                      r_s2_v;
    t_tag                      r_s2_tag;
    logic signed [PROD_W-1:0]  r_s2_p1, r_s2_p2;
    logic                      r_s3_v;
    t_tag                      r_s3_tag;
    logic [AREA_W-1:0]         r_s3_area;
    logic signed [CROSS_W-1:0] cross_val;
    logic [CROSS_W-1:0]        mag;
    logic [MAG_W-1:0]          mag_w;
    logic [AREA_W-1:0]         area;
    logic                      pipe_busy;
    logic                      found;

    assign o_item_pop = (r_state == S_LOAD) && !i_item_empty;
    assign wr_en      = o_item_pop && i_item.store;
    assign wr_cnt     = i_item.cnt - CNT_W'(1);
    assign pipe_busy  = r_rd_v || r_s1_v || r_s2_v || r_s3_v;
    assign found      = (r_best != '0);
    assign o_result   = r_out;
    assign o_empty    = !r_out_v;

    always_comb begin
        addr_a = r_k;
        addr_b = r_j;
        case (r_state)
            S_FETCH_I: begin
                addr_b = r_i;
            end
            S_RES_A: begin
                addr_a = r_best_tag.i;
                addr_b = r_best_tag.j;
            end
            S_RES_B: begin
                addr_a = r_best_tag.k;
            end
            default: begin
                addr_a = r_k;
                addr_b = r_j;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_cnt[IDX_W-1:0]] <= i_item.pt;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    // saturating magnitude of the cross product
    always_comb begin
        cross_val = CROSS_W'(r_s2_p1) - CROSS_W'(r_s2_p2);
        mag       = cross_val[CROSS_W-1] ? CROSS_W'(-cross_val) : CROSS_W'(cross_val);
        mag_w     = MAG_W'(mag);
        area      = (mag_w > MAG_W'(AREA_MAX)) ? AREA_MAX : mag_w[AREA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_SCAN);
            r_s1_v <= r_rd_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // read port b holds point j through the whole k sweep
    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH_J) begin
            r_pi <= r_rd_b;
        end
        r_rd_tag  <= '{i: r_i, j: r_j, k: r_k};
        r_s1_tag  <= r_rd_tag;
        r_s1_d1x  <= DIFF_W'(r_rd_b.x) - DIFF_W'(r_pi.x);
        r_s1_d1y  <= DIFF_W'(r_rd_b.y) - DIFF_W'(r_pi.y);
        r_s1_d2x  <= DIFF_W'(r_rd_a.x) - DIFF_W'(r_pi.x);
        r_s1_d2y  <= DIFF_W'(r_rd_a.y) - DIFF_W'(r_pi.y);
        r_s2_tag  <= r_s1_tag;
        r_s2_p1   <= r_s1_d1x * r_s1_d2y;
        r_s2_p2   <= r_s1_d2x * r_s1_d1y;
        r_s3_tag  <= r_s2_tag;
        r_s3_area <= area;
    end

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_n        = r_n;
        n_dropped  = r_dropped;
        n_best     = r_best;
        n_best_tag = r_best_tag;
        n_res      = r_res;
        n_out      = r_out;
        n_out_v    = r_out_v;

        // strictly greater keeps the earliest triple on a tie
        if (r_s3_v && (r_s3_area > r_best)) begin
            n_best     = r_s3_area;
            n_best_tag = r_s3_tag;
        end

        if (i_pop && r_out_v) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (o_item_pop && i_item.last) begin
                    n_n        = i_item.cnt;
                    n_dropped  = i_item.dropped;
                    n_best     = '0;
                    n_best_tag = '0;
                    n_i        = '0;
                    n_j        = IDX_W'(1);
                    n_state    = (i_item.cnt < CNT_W'(MIN_POINTS)) ? S_RES_A : S_FETCH_I;
                end
            end
            S_FETCH_I: begin
                n_state = S_FETCH_J;
            end
            S_FETCH_J: begin
                n_k     = r_j + IDX_W'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (CNT_W'(r_k) == r_n - CNT_W'(1)) begin
                    if (CNT_W'(r_j) == r_n - CNT_W'(2)) begin
                        if (CNT_W'(r_i) == r_n - CNT_W'(3)) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_i     = r_i + IDX_W'(1);
                            n_j     = r_i + IDX_W'(2);
                            n_state = S_FETCH_I;
                        end
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_FETCH_I;
                    end
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = S_RES_A;
                end
            end
            S_RES_A: begin
                n_state = S_RES_B;
            end
            S_RES_B: begin
                n_res.first_x  = found ? to_out(r_rd_a.x) : '0;
                n_res.first_y  = found ? to_out(r_rd_a.y) : '0;
                n_res.second_x = found ? to_out(r_rd_b.x) : '0;
                n_res.second_y = found ? to_out(r_rd_b.y) : '0;
                n_state        = S_RES_C;
            end
            S_RES_C: begin
                n_res.third_x     = found ? to_out(r_rd_a.x) : '0;
                n_res.third_y     = found ? to_out(r_rd_a.y) : '0;
                n_res.double_area = r_best;
                n_res.found       = found;
                n_res.overflow    = r_dropped;
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_v || i_pop) begin
                    n_out      = r_res;
                    n_out_v    = 1'b1;
                    n_best     = '0;
                    n_best_tag = '0;
                    n_dropped  = 1'b0;
                    n_n        = '0;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_n        <= '0;
            r_dropped  <= 1'b0;
            r_best     <= '0;
            r_best_tag <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_n        <= n_n;
            r_dropped  <= n_dropped;
            r_best     <= n_best;
            r_best_tag <= n_best_tag;
            r_out_v    <= n_out_v;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

// ===== rtl/mats_checker.sv =====
// port-level checks of the triangle search unit, bound to the top level
`include "max_area_triangle_search_unit_defines.svh"

module mats_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        push,
    input logic                        full,
    input logic signed [15:0]          i_x_coord,
    input logic signed [15:0]          i_y_coord,
    input logic                        i_last_point,
    input logic                        empty,
    input logic                        pop,
    input logic signed [15:0]          o_first_x,
    input logic signed [15:0]          o_first_y,
    input logic signed [15:0]          o_second_x,
    input logic signed [15:0]          o_second_y,
    input logic signed [15:0]          o_third_x,
    input logic signed [15:0]          o_third_y,
    input logic [mats_pkg::AREA_W-1:0] o_double_area,
    input logic                        o_found,
    input logic                        o_overflow
);

    // reset leaves no result waiting and room in the queue
    `MATS_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n |=> empty && !full, "result or full after reset")

    // a waiting beat holds until popped
    `MATS_ASSERT(a_result_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_double_area) && $stable(o_first_x) && $stable(o_third_y) && $stable(o_overflow), "waiting result changed")

    // found agrees with a non-zero area
    `MATS_ASSERT(a_found_area, i_clk, i_rst_n, !empty |-> o_found == (o_double_area != 0), "found disagrees with area")

    // no triangle means all vertices zero
    `MATS_ASSERT(a_empty_vertices, i_clk, i_rst_n, !empty && !o_found |-> o_first_x == 0 && o_first_y == 0 && o_second_x == 0 && o_second_y == 0 && o_third_x == 0 && o_third_y == 0, "vertices set without a triangle")

endmodule

bind max_area_triangle_search_unit mats_checker u_mats_checker (.*);
